// ===== rtl/iolot_pkg.sv =====
// shared constants, types and request codes of the io line ownership table
package iolot_pkg;

   localparam int LINES   = 32;
   localparam int ID_BITS = 8;
   localparam int MASK_W  = 32;
   localparam int INDEX_W = 8;
   localparam int GRANT_W = 8;
   localparam int OP_W    = 4;
   // candidate ids run from 1 to LINES+1
   localparam int CAND_W  = $clog2(LINES + 2);

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC_MASK = 4'd0,
      OP_ALLOC_AUTO = 4'd1,
      OP_ALLOC_ID   = 4'd2,
      OP_FREE_ID    = 4'd3,
      OP_FREE_ALL   = 4'd4,
      OP_Q_MASK_ID  = 4'd5,
      OP_Q_MASK     = 4'd6,
      OP_Q_LINE_ID  = 4'd7,
      OP_Q_LINE     = 4'd8
   } op_type;

   typedef struct packed {
      logic load;
      logic search_start;
      logic search_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic needs_search;
      logic cand_free;
      logic cand_last;
   } sts_type;

endpackage

// ===== rtl/iolot_req_if.sv =====
// request channel: one ownership request word per handshake
interface iolot_req_if;
   import iolot_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [MASK_W-1:0]   line_mask;
   logic [INDEX_W-1:0]  line_index;
   logic [INDEX_W-1:0]  owner_id;

   modport source (output valid, op, line_mask, line_index, owner_id, input ready);
   modport sink   (input valid, op, line_mask, line_index, owner_id, output ready);
endinterface

// ===== rtl/iolot_rsp_if.sv =====
// response channel: one result word per handshake
interface iolot_rsp_if;
   import iolot_pkg::*;

   logic                valid;
   logic                ready;
   logic                status;
   logic [GRANT_W-1:0]  granted_id;
   logic [MASK_W-1:0]   conflict_mask;
   logic                answer;

   modport source (output valid, status, granted_id, conflict_mask, answer, input ready);
   modport sink   (input valid, status, granted_id, conflict_mask, answer, output ready);
endinterface

// ===== rtl/io_line_ownership_table_top.sv =====
// top level of the io line ownership table
// Keeps one owner id per io line (0 = free) and serves one request word at a
// time: allocate by mask or one line, free by id or all, and ownership queries.
// Each request runs load, evaluate and commit from acceptance to response;
// allocations that need a fresh id add a search state between, trying up to
// LINES+1 candidate ids, since the free id search checks one candidate per
// cycle against all lines at once. The response sits in an output register,
// so the next request is taken while a response waits; a commit only waits
// when that register is still full. The table is cleared by reset.
module io_line_ownership_table_top
   import iolot_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   iolot_req_if.sink    req_chan,
   iolot_rsp_if.source  rsp_chan
);

   cmd_type cmd;   // sequencer commands to the datapath
   sts_type sts;   // evaluation and search status back

   // sequencer: handshakes and the free id search loop
   iolot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table, request word registers and response word register
   iolot_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_op            (req_chan.op),
      .req_line_mask     (req_chan.line_mask),
      .req_line_index    (req_chan.line_index),
      .req_owner_id      (req_chan.owner_id),
      .rsp_status        (rsp_chan.status),
      .rsp_granted_id    (rsp_chan.granted_id),
      .rsp_conflict_mask (rsp_chan.conflict_mask),
      .rsp_answer        (rsp_chan.answer)
   );

endmodule

// ===== rtl/iolot_datapath.sv =====
// ownership table, request registers, free id search counter and result register
module iolot_datapath
   import iolot_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [OP_W-1:0]     req_op,
   input  logic [MASK_W-1:0]   req_line_mask,
   input  logic [INDEX_W-1:0]  req_line_index,
   input  logic [INDEX_W-1:0]  req_owner_id,
   output logic                rsp_status,
   output logic [GRANT_W-1:0]  rsp_granted_id,
   output logic [MASK_W-1:0]   rsp_conflict_mask,
   output logic                rsp_answer
);

   logic [ID_BITS-1:0] owner_ff [LINES];
   logic [ID_BITS-1:0] owner_in [LINES];

   logic [OP_W-1:0]    op_ff;
   logic [MASK_W-1:0]  mask_ff;
   logic [INDEX_W-1:0] line_ff;
   logic [ID_BITS-1:0] id_ff;
   logic [CAND_W-1:0]  cand_ff;
   logic [CAND_W-1:0]  cand_in;

   logic               status_ff,   status_in;
   logic [GRANT_W-1:0] granted_ff,  granted_in;
   logic [MASK_W-1:0]  conflict_ff, conflict_in;
   logic               answer_ff,   answer_in;

   logic [MASK_W-1:0]  conflict;
   logic [ID_BITS-1:0] sel_owner;
   logic               in_range;
   logic               cand_held;
   logic               mask_id_all;
   logic               mask_owned_all;
   logic [ID_BITS-1:0] cand_id;

   assign cand_id  = ID_BITS'(cand_ff);
   assign in_range = line_ff < INDEX_W'(LINES);

   // per-line compares, all lines in parallel
   always_comb begin
      conflict       = '0;
      sel_owner      = '0;
      cand_held      = 1'b0;
      mask_id_all    = 1'b1;
      mask_owned_all = 1'b1;
      for (int k = 0; k < LINES; k++) begin
         if (mask_ff[k] && owner_ff[k] != '0) conflict[k] = 1'b1;
         if (line_ff == INDEX_W'(k)) sel_owner = owner_ff[k];
         if (owner_ff[k] == cand_id) cand_held = 1'b1;
         if (mask_ff[k] && (owner_ff[k] == '0 || owner_ff[k] != id_ff)) mask_id_all = 1'b0;
         if (mask_ff[k] && owner_ff[k] == '0) mask_owned_all = 1'b0;
      end
   end

   always_comb begin
      sts.needs_search = (op_ff == OP_ALLOC_MASK && conflict == '0) ||
                         (op_ff == OP_ALLOC_AUTO && in_range && sel_owner == '0);
      sts.cand_free    = !cand_held;
      sts.cand_last    = cand_ff == CAND_W'(LINES + 1);
   end

   always_comb begin
      cand_in = cand_ff;
      if (cmd.search_start)     cand_in = CAND_W'(1);
      else if (cmd.search_step) cand_in = cand_ff + CAND_W'(1);
   end

   // result and next table contents for the request held
   always_comb begin
      owner_in    = owner_ff;
      status_in   = 1'b0;
      granted_in  = '0;
      conflict_in = '0;
      answer_in   = 1'b0;
      unique case (op_ff)
         OP_ALLOC_MASK: begin
            if (conflict != '0) begin
               status_in   = 1'b1;
               conflict_in = conflict;
            end else begin
               granted_in = GRANT_W'(cand_ff);
               for (int k = 0; k < LINES; k++)
                  if (mask_ff[k]) owner_in[k] = cand_id;
            end
         end
         OP_ALLOC_AUTO, OP_ALLOC_ID: begin
            if (!in_range || sel_owner != '0) begin
               status_in = 1'b1;
            end else begin
               granted_in = (op_ff == OP_ALLOC_AUTO) ? GRANT_W'(cand_ff) : GRANT_W'(id_ff);
               for (int k = 0; k < LINES; k++)
                  if (line_ff == INDEX_W'(k))
                     owner_in[k] = (op_ff == OP_ALLOC_AUTO) ? cand_id : id_ff;
            end
         end
         OP_FREE_ID: begin
            for (int k = 0; k < LINES; k++)
               if (owner_ff[k] == id_ff) owner_in[k] = '0;
         end
         OP_FREE_ALL: begin
            for (int k = 0; k < LINES; k++) owner_in[k] = '0;
         end
         OP_Q_MASK_ID: answer_in = mask_id_all;
         OP_Q_MASK:    answer_in = mask_owned_all;
         OP_Q_LINE_ID: answer_in = in_range && sel_owner == id_ff;
         OP_Q_LINE:    answer_in = in_range && sel_owner != '0;
         default:      status_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LINES; k++) owner_ff[k] <= '0;
      end else if (cmd.commit) begin
         owner_ff <= owner_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         mask_ff <= req_line_mask;
         line_ff <= req_line_index;
         id_ff   <= ID_BITS'(req_owner_id);
      end
      cand_ff <= cand_in;
      if (cmd.commit) begin
         status_ff   <= status_in;
         granted_ff  <= granted_in;
         conflict_ff <= conflict_in;
         answer_ff   <= answer_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_granted_id    = granted_ff;
   assign rsp_conflict_mask = conflict_ff;
   assign rsp_answer        = answer_ff;

endmodule

// ===== rtl/iolot_ctrl.sv =====
// request sequencer: accept, evaluate, free id search, commit
module iolot_ctrl
   import iolot_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EVAL   = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.needs_search) begin
               cmd.search_start = 1'b1;
               state_in         = ST_SEARCH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SEARCH: begin
            if (sts.cand_free || sts.cand_last) state_in = ST_FINISH;
            else cmd.search_step = 1'b1;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_EVAL)
      else $error("accepted request did not move to evaluation");

   a_commit_out: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("commit did not present a response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready |=> state_ff == ST_FINISH)
      else $error("pending response overwritten");

   a_search_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH && !sts.cand_free && !sts.cand_last |=> state_ff == ST_SEARCH)
      else $error("free id search left early");

endmodule

// ===== dv/iolot_ownership_monitor.sv =====
// watches both channels, mirrors the ownership table and checks every response word
`timescale 1ns / 1ps

module iolot_ownership_monitor
   import iolot_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   iolot_req_if    req_chan,
   iolot_rsp_if    rsp_chan,
   output int      mismatches,
   output int      outstanding
);

   typedef struct packed {
      logic                status;
      logic [GRANT_W-1:0]  granted_id;
      logic [MASK_W-1:0]   conflict_mask;
      logic                answer;
   } rsp_word_type;

   logic [ID_BITS-1:0] owner_of [LINES];
   rsp_word_type       pending_rsp [$];

   // applies one request to the mirrored table, returns the response it earns
   function automatic rsp_word_type serve_request(input logic [OP_W-1:0]    op,
                                                  input logic [MASK_W-1:0]  mask,
                                                  input logic [INDEX_W-1:0] index,
                                                  input logic [INDEX_W-1:0] id_in);
      rsp_word_type        r;
      logic [ID_BITS-1:0]  id;
      logic [MASK_W-1:0]   held;
      logic [GRANT_W-1:0]  fresh;
      logic                in_range;
      logic                taken;
      r        = '0;
      id       = ID_BITS'(id_in);
      in_range = (int'(index) < LINES);
      held     = '0;
      for (int k = 0; k < LINES; k++)
         if (owner_of[k] != '0) held[k] = 1'b1;
      // lowest id of 1 or more that no line holds
      fresh = GRANT_W'(LINES + 1);
      for (int c = LINES; c >= 1; c--) begin
         taken = 1'b0;
         for (int k = 0; k < LINES; k++)
            if (owner_of[k] == ID_BITS'(c)) taken = 1'b1;
         if (!taken) fresh = GRANT_W'(c);
      end
      case (op)
         OP_ALLOC_MASK: begin
            r.conflict_mask = mask & held;
            if (r.conflict_mask != '0) begin
               r.status = 1'b1;
            end else begin
               r.granted_id = fresh;
               for (int k = 0; k < LINES; k++)
                  if (mask[k]) owner_of[k] = ID_BITS'(fresh);
            end
         end
         OP_ALLOC_AUTO: begin
            if (!in_range || owner_of[index] != '0) begin
               r.status = 1'b1;
            end else begin
               r.granted_id    = fresh;
               owner_of[index] = ID_BITS'(fresh);
            end
         end
         OP_ALLOC_ID: begin
            if (!in_range || owner_of[index] != '0) begin
               r.status = 1'b1;
            end else begin
               r.granted_id    = GRANT_W'(id);
               owner_of[index] = id;
            end
         end
         OP_FREE_ID: begin
            for (int k = 0; k < LINES; k++)
               if (owner_of[k] == id) owner_of[k] = '0;
         end
         OP_FREE_ALL: begin
            for (int k = 0; k < LINES; k++) owner_of[k] = '0;
         end
         OP_Q_MASK_ID: begin
            r.answer = 1'b1;
            for (int k = 0; k < LINES; k++)
               if (mask[k] && (owner_of[k] == '0 || owner_of[k] != id)) r.answer = 1'b0;
         end
         OP_Q_MASK: begin
            r.answer = 1'b1;
            for (int k = 0; k < LINES; k++)
               if (mask[k] && owner_of[k] == '0) r.answer = 1'b0;
         end
         OP_Q_LINE_ID: r.answer = in_range && (owner_of[index] == id);
         OP_Q_LINE:    r.answer = in_range && (owner_of[index] != '0);
         default:      r.status = 1'b1;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         pending_rsp.delete();
         for (int k = 0; k < LINES; k++) owner_of[k] = '0;
         mismatches = 0;
         outstanding <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response word with no request waiting");
               mismatches++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  mismatches++;
               end
               if (rsp_chan.granted_id !== want.granted_id) begin
                  $error("granted_id: expected %0d, got %0d",
                         want.granted_id, rsp_chan.granted_id);
                  mismatches++;
               end
               if (rsp_chan.conflict_mask !== want.conflict_mask) begin
                  $error("conflict_mask: expected %h, got %h",
                         want.conflict_mask, rsp_chan.conflict_mask);
                  mismatches++;
               end
               if (rsp_chan.answer !== want.answer) begin
                  $error("answer: expected %0d, got %0d", want.answer, rsp_chan.answer);
                  mismatches++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            pending_rsp.push_back(serve_request(req_chan.op, req_chan.line_mask,
                                                req_chan.line_index, req_chan.owner_id));
         outstanding <= pending_rsp.size();
      end
   end

endmodule

// ===== dv/tb.sv =====
// stimulus, clocking and verdict for the io line ownership table
`timescale 1ns / 1ps

module tb;
   import iolot_pkg::*;

   // run length and stall shaping
   localparam int RANDOM_WORDS    = 1000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int PRESSURE_AT     = 400;
   localparam int PRESSURE_WORDS  = 40;
   localparam int DRAIN_CYCLES    = 60;
   localparam int CYCLE_LIMIT     = 1_000_000;
   // op codes past the last defined request are all illegal
   localparam int OP_FIRST_UNUSED = int'(OP_Q_LINE) + 1;
   localparam int OP_CODES        = 1 << OP_W;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   cycle_count = 0;
   int   words_sent  = 0;
   logic rsp_hold_req;
   logic rsp_hold_done;

   iolot_req_if req_chan ();
   iolot_rsp_if rsp_chan ();

   io_line_ownership_table_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   iolot_ownership_monitor u_ownership_mon (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #1 clock = ~clock;

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("io_line_ownership_table_top test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // field pickers: mostly values that hit the table, now and then anything
   // ---------------------------------------------------------------------

   // short runs of adjacent lines so allocations sometimes succeed
   function automatic logic [MASK_W-1:0] pick_mask();
      int                roll;
      logic [MASK_W-1:0] run;
      roll = $urandom_range(0, 99);
      if (roll < 8) return '0;
      if (roll < 20) return MASK_W'($urandom);
      run = MASK_W'((64'd1 << $urandom_range(1, 4)) - 64'd1);
      return run << $urandom_range(0, LINES - 1);
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index();
      if ($urandom_range(0, 99) < 88) return INDEX_W'($urandom_range(0, LINES - 1));
      return INDEX_W'($urandom_range(0, 255));
   endfunction

   // low ids dominate so frees and id queries land on held ids
   function automatic logic [INDEX_W-1:0] pick_id();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8)  return '0;
      if (roll < 80) return INDEX_W'($urandom_range(1, 12));
      if (roll < 92) return INDEX_W'($urandom_range(13, LINES + 1));
      return INDEX_W'($urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------

   // offer one request word and hold it until the block takes it;
   // valid stays high so a back-to-back word needs no drop
   task automatic send_word(input logic [OP_W-1:0]    op,
                            input logic [MASK_W-1:0]  mask,
                            input logic [INDEX_W-1:0] index,
                            input logic [INDEX_W-1:0] id);
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.line_mask  <= mask;
      req_chan.line_index <= index;
      req_chan.owner_id   <= id;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
   endtask

   // random idle time between words, mostly none or short
   task automatic sender_gap();
      int roll;
      int n;
      roll = $urandom_range(0, 99);
      if (roll < 60)      n = 0;
      else if (roll < 95) n = $urandom_range(1, 3);
      else                n = $urandom_range(10, 40);
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // stop offering and wait until every response word is back
   task automatic drain_wait();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // one request with a weighted op mix
   task automatic random_word();
      int              roll;
      logic [OP_W-1:0] op;
      roll = $urandom_range(0, 99);
      if (roll < 14)      op = OP_ALLOC_MASK;
      else if (roll < 30) op = OP_ALLOC_AUTO;
      else if (roll < 42) op = OP_ALLOC_ID;
      else if (roll < 55) op = OP_FREE_ID;
      else if (roll < 58) op = OP_FREE_ALL;
      else if (roll < 68) op = OP_Q_MASK_ID;
      else if (roll < 76) op = OP_Q_MASK;
      else if (roll < 86) op = OP_Q_LINE_ID;
      else if (roll < 96) op = OP_Q_LINE;
      else                op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_CODES - 1));
      send_word(op, pick_mask(), pick_index(), pick_id());
      sender_gap();
   endtask

   // fill every line with its own fresh id, so the search runs to the end
   task automatic fill_table();
      int rot;
      rot = $urandom_range(0, LINES - 1);
      send_word(OP_FREE_ALL, MASK_W'($urandom), pick_index(), pick_id());
      for (int k = 0; k < LINES; k++)
         send_word(OP_ALLOC_AUTO, MASK_W'($urandom), INDEX_W'((k + rot) % LINES), pick_id());
      // empty mask with every id held: fresh id is one past the line count
      send_word(OP_ALLOC_MASK, '0, pick_index(), pick_id());
      send_word(OP_Q_MASK, '1, pick_index(), pick_id());
      sender_gap();
   endtask

   initial begin
      int  roll;
      logic pressure_done;
      pressure_done       = 1'b0;
      reset              <= 1'b1;
      rsp_hold_req       <= 1'b0;
      req_chan.valid     <= 1'b0;
      req_chan.op        <= OP_ALLOC_MASK;
      req_chan.line_mask <= '0;
      req_chan.line_index <= '0;
      req_chan.owner_id  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part: corners of every request ----
      send_word(OP_Q_LINE,     '0,            8'd0,   8'd0);   // free line reads unowned
      send_word(OP_ALLOC_MASK, '0,            8'd0,   8'd0);   // empty mask, id granted anyway
      send_word(OP_ALLOC_MASK, 32'h0000_000F, 8'd0,   8'd0);
      send_word(OP_ALLOC_MASK, 32'h0000_0018, 8'd0,   8'd0);   // overlaps line 3
      send_word(OP_ALLOC_AUTO, '0,            8'd31,  8'd0);   // top line
      send_word(OP_ALLOC_AUTO, '0,            8'd32,  8'd0);   // just out of range
      send_word(OP_ALLOC_AUTO, '1,            8'd255, 8'd255); // far out of range
      send_word(OP_ALLOC_ID,   '0,            8'd4,   8'd255); // largest id
      send_word(OP_ALLOC_ID,   '0,            8'd5,   8'd0);   // id zero leaves it free
      send_word(OP_ALLOC_ID,   '0,            8'd4,   8'd7);   // already owned
      send_word(OP_Q_MASK_ID,  32'h0000_000F, 8'd0,   8'd1);
      send_word(OP_Q_MASK_ID,  '0,            8'd0,   8'd0);   // empty mask answers true
      send_word(OP_Q_MASK_ID,  32'h0000_0020, 8'd0,   8'd0);   // id zero on a free line
      send_word(OP_Q_MASK,     '1,            8'd0,   8'd0);
      send_word(OP_Q_MASK,     '0,            8'd0,   8'd0);
      send_word(OP_Q_LINE_ID,  '0,            8'd5,   8'd0);   // free line matches id zero
      send_word(OP_Q_LINE_ID,  '0,            8'd200, 8'd0);   // out of range answers false
      send_word(OP_Q_LINE,     '0,            8'd31,  8'd0);
      send_word(OP_Q_LINE,     '0,            8'd255, 8'd0);
      send_word(OP_FREE_ID,    '0,            8'd0,   8'd0);   // id zero frees nothing
      send_word(OP_FREE_ID,    '0,            8'd0,   8'd1);
      send_word(OP_W'(OP_FIRST_UNUSED), '1,   8'd255, 8'd255); // illegal codes
      send_word(OP_W'(OP_CODES - 1),    '1,   8'd255, 8'd255);
      send_word(OP_FREE_ALL,   '0,            8'd0,   8'd0);
      send_word(OP_ALLOC_MASK, '1,            8'd0,   8'd0);   // every line at once
      send_word(OP_FREE_ALL,   '0,            8'd0,   8'd0);
      drain_wait();

      // ---- random part: bursts, full-table runs and drain pauses ----
      while (words_sent < RANDOM_WORDS) begin
         if (!pressure_done && words_sent >= PRESSURE_AT) begin
            // receiver stops for a long while; keep offering until its hold-off is over
            pressure_done = 1'b1;
            rsp_hold_req <= 1'b1;
            repeat (PRESSURE_WORDS)
               send_word(OP_W'($urandom_range(0, int'(OP_Q_LINE))),
                         pick_mask(), pick_index(), pick_id());
            while (!rsp_hold_done)
               send_word(OP_W'($urandom_range(0, int'(OP_Q_LINE))),
                         pick_mask(), pick_index(), pick_id());
            drain_wait();
         end
         roll = $urandom_range(0, 99);
         if (roll < 4)
            fill_table();
         else if (roll < 9)
            drain_wait();
         else
            repeat ($urandom_range(1, 12)) random_word();
      end

      // ---- wrap up ----
      drain_wait();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("io_line_ownership_table_top test passed");
      else
         $display("io_line_ownership_table_top test failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // receiver side: random back-pressure plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      int roll;
      int stall;
      rsp_chan.ready <= 1'b0;
      rsp_hold_done  <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req && !rsp_hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_chan.ready <= 1'b1;
            rsp_hold_done  <= 1'b1;
            @(posedge clock);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 55)      stall = 0;
            else if (roll < 93) stall = $urandom_range(1, 4);
            else                stall = $urandom_range(15, 60);
            if (stall > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            // occasionally a long stretch of steady ready
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, (roll < 10) ? 80 : 6)) @(posedge clock);
         end
      end
   end

endmodule
